FILE: rtl/slft_pkg.sv
// ----------------------------------------------------------------------------
// Sorted line table package
// Shared types, sizes and codes for the sorted line-information table.
// ----------------------------------------------------------------------------
`default_nettype none

package slft_pkg;

	localparam int ENTRIES     = 256;
	localparam int COUNT_W     = $clog2(ENTRIES + 1);
	localparam int GROUP_SIZE  = 16;
	localparam int NUM_GROUPS  = (ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int OFFSET_W    = 32;
	localparam int LINE_W      = 31;
	localparam int FILE_W      = 8;
	localparam int ENTRY_W     = OFFSET_W + LINE_W + FILE_W;
	localparam int STATUS_W    = 3;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_HIT       = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_MISS      = 3'd4;

	typedef struct packed {
		logic [OFFSET_W-1:0] offset;
		logic [LINE_W-1:0]   line;
		logic [FILE_W-1:0]   file;
	} entry_t;

	typedef struct packed {
		logic cmp;
		logic ins;
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/slft_cell.sv
// ----------------------------------------------------------------------------
// Sorted line table cell
// Holds one table entry, compares it against the key and shifts on insert.
// ----------------------------------------------------------------------------
`default_nettype none

module slft_cell
	import slft_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cell_ctl_t           ctl,
	input  wire logic [OFFSET_W-1:0] key,
	input  wire logic                valid,
	input  wire entry_t              new_entry,
	input  wire entry_t              left_entry,
	input  wire logic                left_le,
	input  wire logic                right_le,
	output entry_t                   entry,
	output logic                     le,
	output logic                     eq,
	output logic [ENTRY_W-1:0]       hit_entry
);

	entry_t entry_q;
	logic   le_q;
	logic   eq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			le_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctl.cmp) begin
			le_q <= valid && (entry_q.offset <= key);
			eq_q <= valid && (entry_q.offset == key);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins && !le_q) begin
			if (left_le) begin
				entry_q <= new_entry;
			end else begin
				entry_q <= left_entry;
			end
		end
	end

	assign entry     = entry_q;
	assign le        = le_q;
	assign eq        = eq_q;
	assign hit_entry = (le_q && !right_le) ? entry_q : '0;

endmodule

`default_nettype wire

FILE: rtl/sorted_line_info_floor_table.sv
// ----------------------------------------------------------------------------
// Sorted line-information floor table
// Sorted (offset, line, file) table with shifting insert and floor lookup.
// ----------------------------------------------------------------------------
// Usage: items arrive on the input channel (in_valid / in_stall) and each
// transfer yields exactly one result on the output channel (out_valid /
// out_stall). An insert places the entry in offset order, reporting a
// duplicate offset or a full table instead. A lookup returns the entry with
// the greatest offset not above the query, or a miss when the table is
// empty, the query lies below the first entry or above section_size.
// section_size is written through cfg_valid / cfg_ready / cfg_data, which
// always accepts; write it only while no item is in flight.
// Every cell compares its entry with the key in the compare state, the cells
// shift or answer in the execute state, and a lookup then passes through a
// registered two-level OR tree over the one-hot hit cells in a reduce state;
// an insert goes straight to the output state. The next item is taken once the
// result has been loaded into the output register, so a result waiting
// under out_stall lets the next item start but holds back its result.
// Reset empties the table and clears section_size; no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_line_info_floor_table
	import slft_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                operation,
	input  wire logic [OFFSET_W-1:0] offset,
	input  wire logic [LINE_W-1:0]   line_number,
	input  wire logic [FILE_W-1:0]   file_id,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [STATUS_W-1:0]      status,
	output logic [OFFSET_W-1:0]      found_offset,
	output logic [LINE_W-1:0]        found_line,
	output logic [FILE_W-1:0]        found_file,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [OFFSET_W-1:0] cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CMP  = 3'd1;
	localparam logic [2:0] ST_EXE  = 3'd2;
	localparam logic [2:0] ST_RED  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]          state_q;
	logic                op_q;
	logic [OFFSET_W-1:0] key_q;
	entry_t              new_entry;
	logic [OFFSET_W-1:0] section_size_q;
	logic [COUNT_W-1:0]  count_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [ENTRY_W-1:0]  res_entry_q;
	logic [ENTRY_W-1:0]  group_q [NUM_GROUPS];
	logic [ENTRY_W-1:0]  group_d [NUM_GROUPS];
	logic [ENTRY_W-1:0]  tree_or;
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	entry_t              out_entry_q;

	cell_ctl_t           ctl;
	entry_t              entry_vec [ENTRIES];
	logic [ENTRY_W-1:0]  hit_vec   [ENTRIES];
	logic [ENTRIES-1:0]  le_vec;
	logic [ENTRIES-1:0]  eq_vec;
	logic [ENTRIES-1:0]  valid_vec;

	logic in_xfer;
	logic out_free;
	logic is_dup;
	logic is_full;
	logic is_hit;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;
	assign is_dup    = |eq_vec;
	assign is_full   = (count_q == COUNT_W'(ENTRIES));
	assign is_hit    = le_vec[0] && (key_q <= section_size_q);

	assign ctl.cmp = (state_q == ST_CMP);
	assign ctl.ins = (state_q == ST_EXE) && (op_q == OP_INSERT) && !is_dup && !is_full;

	genvar gi;
	generate
		for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
			entry_t left_entry;
			logic   left_le;
			logic   right_le;

			assign valid_vec[gi] = (count_q > COUNT_W'(gi));

			if (gi == 0) begin : g_first
				assign left_entry = new_entry;
				assign left_le    = 1'b1;
			end else begin : g_mid
				assign left_entry = entry_vec[gi-1];
				assign left_le    = le_vec[gi-1];
			end

			if (gi == ENTRIES - 1) begin : g_last
				assign right_le = 1'b0;
			end else begin : g_inner
				assign right_le = le_vec[gi+1];
			end

			slft_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.key        (key_q),
				.valid      (valid_vec[gi]),
				.new_entry  (new_entry),
				.left_entry (left_entry),
				.left_le    (left_le),
				.right_le   (right_le),
				.entry      (entry_vec[gi]),
				.le         (le_vec[gi]),
				.eq         (eq_vec[gi]),
				.hit_entry  (hit_vec[gi])
			);
		end
	endgenerate

	always_comb begin
		for (int g = 0; g < NUM_GROUPS; g++) begin
			group_d[g] = '0;
			for (int k = 0; k < GROUP_SIZE; k++) begin
				if (g * GROUP_SIZE + k < ENTRIES) begin
					group_d[g] = group_d[g] | hit_vec[g * GROUP_SIZE + k];
				end
			end
		end
	end

	always_comb begin
		tree_or = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			tree_or = tree_or | group_q[g];
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q             <= operation;
			key_q            <= offset;
			new_entry.offset <= offset;
			new_entry.line   <= line_number;
			new_entry.file   <= file_id;
		end
		if (state_q == ST_EXE) begin
			for (int g = 0; g < NUM_GROUPS; g++) begin
				group_q[g] <= group_d[g];
			end
		end
		if (state_q == ST_EXE && op_q == OP_INSERT) begin
			res_entry_q <= '0;
			if (is_dup) begin
				res_status_q <= STAT_DUPLICATE;
			end else if (is_full) begin
				res_status_q <= STAT_FULL;
			end else begin
				res_status_q <= STAT_INSERTED;
			end
		end else if (state_q == ST_RED) begin
			res_status_q <= is_hit ? STAT_HIT : STAT_MISS;
			res_entry_q  <= is_hit ? tree_or : '0;
		end
		if (state_q == ST_OUT && out_free) begin
			out_status_q <= res_status_q;
			out_entry_q  <= res_entry_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			section_size_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				section_size_q <= cfg_data;
			end
			if (ctl.ins) begin
				count_q <= count_q + COUNT_W'(1);
			end
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_EXE;
				end
				ST_EXE: begin
					state_q <= (op_q == OP_INSERT) ? ST_OUT : ST_RED;
				end
				ST_RED: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign found_offset = out_entry_q.offset;
	assign found_line   = out_entry_q.line;
	assign found_file   = out_entry_q.file;

endmodule

`default_nettype wire

FILE: rtl/slft_checker.sv
// ----------------------------------------------------------------------------
// Sorted line table checker
// Port-level properties of the sorted line-information floor table.
// ----------------------------------------------------------------------------
`default_nettype none

module slft_checker
	import slft_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire logic [STATUS_W-1:0] status,
	input wire logic [OFFSET_W-1:0] found_offset,
	input wire logic [LINE_W-1:0]   found_line,
	input wire logic [FILE_W-1:0]   found_file
);

	// A stalled result holds its status.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
	else $error("stalled result changed");

	// One item is worked on at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
	else $error("input taken while busy");

	// A result never follows its own transfer in the very next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid)
	else $error("result appeared too early");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= STAT_MISS)
	else $error("status code out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_HIT |->
			found_offset == '0 && found_line == '0 && found_file == '0)
	else $error("found fields set without a hit");

endmodule

bind sorted_line_info_floor_table slft_checker u_slft_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.found_offset (found_offset),
	.found_line   (found_line),
	.found_file   (found_file)
);

`default_nettype wire
